>>> rtl/core/tx_descriptor_list_walker_macros.svh
// Assertion helpers for the transmit descriptor walker
`ifndef TX_DESCRIPTOR_LIST_WALKER_MACROS_SVH
`define TX_DESCRIPTOR_LIST_WALKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TDLW_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdlw check failed");

// next-cycle implication, checked outside reset
`define TDLW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdlw check failed");

`endif

>>> rtl/core/tdlw_pkg.sv
`default_nettype none

package tdlw_pkg;

    // walk limits
    localparam int MAX_DESCRIPTORS = 64;
    localparam int MAX_FRAGMENTS   = 16;
    localparam int MAX_FRAME_BYTES = 4608;

    // header and fragment bits
    localparam int HDR_DONE_BIT   = 16;
    localparam int HDR_TX_IND_BIT = 15;
    localparam int HDR_DN_IND_BIT = 31;
    localparam int FRAG_END_BIT   = 31;
    localparam logic [31:0] HDR_DONE = 32'h0001_0000;

    // event codes
    localparam logic [2:0] ACT_WR_FULL = 3'd0;
    localparam logic [2:0] ACT_WR_LOW  = 3'd1;
    localparam logic [2:0] ACT_WR_HIGH = 3'd2;
    localparam logic [2:0] ACT_STALL   = 3'd3;
    localparam logic [2:0] ACT_UNSTALL = 3'd4;
    localparam logic [2:0] ACT_READ    = 3'd5;
    localparam logic [2:0] ACT_COPIED  = 3'd6;
    localparam logic [2:0] ACT_BUS_ERR = 3'd7;

    // request codes
    localparam logic [2:0] REQ_NONE  = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_COPY  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_SEND  = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_NEXT  = 3'd1,
        PH_HDR   = 3'd2,
        PH_FADDR = 3'd3,
        PH_FLEN  = 3'd4,
        PH_COPY  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] value;
    } event_t;

    typedef struct packed {
        logic [2:0]  request_kind;
        logic [31:0] bus_address;
        logic [31:0] request_data;
        logic [12:0] frame_offset;
        logic        download_done_flag;
        logic        transmit_done_flag;
        logic        adapter_fail_flag;
        logic [31:0] list_pointer_now;
        logic        engine_busy;
        logic        last_result;
    } result_t;

    // all results caused by one event
    typedef struct packed {
        logic [1:0]        cnt;
        result_t [2:0]     res;
    } bundle_t;

    // request with status fields left clear
    function automatic result_t mk_res(input logic [2:0] kind, input logic [31:0] addr,
                                       input logic [31:0] data, input logic [12:0] off,
                                       input logic dn, input logic tx, input logic fail);
        result_t r;
        r = '0;
        r.request_kind       = kind;
        r.bus_address        = addr;
        r.request_data       = data;
        r.frame_offset       = off;
        r.download_done_flag = dn;
        r.transmit_done_flag = tx;
        r.adapter_fail_flag  = fail;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tx_descriptor_list_walker.sv
// The results of an event are registered in the result buffer when the event is taken.
// Throughput: one event per cycle while each event yields one result and res_ready stays
// high; an event with two or three results holds the single result port until all are taken.
// A two-entry result buffer lets events keep arriving while a result waits.
// Reset (rst_n low, asynchronous) clears all walker state: idle, pointer zero, not stalled.
`default_nettype none

module tx_descriptor_list_walker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             evt_valid,
    output logic                  evt_ready,
    input  wire tdlw_pkg::event_t evt_data,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output tdlw_pkg::result_t     res_data
);

    // walker state
    tdlw_pkg::phase_t phase_reg, phase_next;
    logic [31:0] list_pointer_reg, list_pointer_next;
    logic [31:0] walk_address_reg, walk_address_next;
    logic [31:0] next_descriptor_reg, next_descriptor_next;
    logic [31:0] frame_header_reg, frame_header_next;
    logic [31:0] frag_slot_reg, frag_slot_next;
    logic [31:0] payload_address_reg, payload_address_next;
    logic [4:0]  fragment_count_reg, fragment_count_next;
    logic [12:0] frame_length_reg, frame_length_next;
    logic [6:0]  descriptor_count_reg, descriptor_count_next;
    logic        last_frag_reg, last_frag_next;
    logic        stalled_reg, stalled_next;

    // result buffer
    tdlw_pkg::bundle_t fifo_reg [2];
    tdlw_pkg::bundle_t bundle_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic [1:0] sub_reg;

    logic evt_fire, res_fire, pop_item;

    // shared decode
    logic        is_idle;
    logic [2:0]  act;
    logic [31:0] val;
    logic [31:0] lp_wr;
    logic        go_kick, go_after, go_cont, go_finish, go_chain, in_flen;
    logic [12:0] frag_len, room, len_c;
    logic        lfs_eff;
    logic [4:0]  fc_eff;
    logic [31:0] fsa_eff;
    logic [6:0]  dc_inc;

    assign evt_ready = (count_reg != 2'd2);
    assign evt_fire  = evt_valid && evt_ready;
    assign res_valid = (count_reg != 2'd0);
    assign res_data  = fifo_reg[rd_ptr_reg].res[sub_reg];
    assign res_fire  = res_valid && res_ready;
    assign pop_item  = res_fire && (sub_reg == fifo_reg[rd_ptr_reg].cnt - 2'd1);

    assign act     = evt_data.action;
    assign val     = evt_data.value;
    assign is_idle = (phase_reg == tdlw_pkg::PH_IDLE);

    // pointer after a write, used for the kick check
    always_comb
    begin
        lp_wr = list_pointer_reg;
        if (is_idle)
        begin
            case (act)
                tdlw_pkg::ACT_WR_FULL: lp_wr = val;
                tdlw_pkg::ACT_WR_LOW:  lp_wr = {list_pointer_reg[31:16], val[15:0]};
                tdlw_pkg::ACT_WR_HIGH: lp_wr = {val[15:0], list_pointer_reg[15:0]};
                default:               lp_wr = list_pointer_reg;
            endcase
        end
    end

    // kick: unstall clears the stall first
    assign go_kick = is_idle && (lp_wr != 32'd0) &&
                     (((act == tdlw_pkg::ACT_WR_FULL || act == tdlw_pkg::ACT_WR_HIGH)
                       && !stalled_reg) || act == tdlw_pkg::ACT_UNSTALL);

    // fragment length clamp against the room left in the frame
    assign frag_len = val[12:0];
    assign room     = (frame_length_reg < 13'(tdlw_pkg::MAX_FRAME_BYTES)) ?
                      (13'(tdlw_pkg::MAX_FRAME_BYTES) - frame_length_reg) : 13'd0;
    assign len_c    = (frag_len > room) ? room : frag_len;

    assign in_flen  = (act == tdlw_pkg::ACT_READ) && (phase_reg == tdlw_pkg::PH_FLEN);
    assign lfs_eff  = in_flen ? val[tdlw_pkg::FRAG_END_BIT] : last_frag_reg;
    assign fc_eff   = in_flen ? fragment_count_reg + 5'd1 : fragment_count_reg;
    assign fsa_eff  = in_flen ? frag_slot_reg + 32'd8 : frag_slot_reg;
    assign dc_inc   = descriptor_count_reg + 7'd1;

    // end of a fragment: zero-length pair or copy done
    assign go_after  = (in_flen && len_c == 13'd0) ||
                       (act == tdlw_pkg::ACT_COPIED && phase_reg == tdlw_pkg::PH_COPY);
    assign go_cont   = go_after && !lfs_eff && (fc_eff < 5'(tdlw_pkg::MAX_FRAGMENTS));
    assign go_finish = go_after && !go_cont;
    assign go_chain  = go_finish && (next_descriptor_reg != 32'd0) && !stalled_reg &&
                       (dc_inc < 7'(tdlw_pkg::MAX_DESCRIPTORS));

    // next state
    always_comb
    begin
        phase_next            = phase_reg;
        list_pointer_next     = lp_wr;
        walk_address_next     = walk_address_reg;
        next_descriptor_next  = next_descriptor_reg;
        frame_header_next     = frame_header_reg;
        frag_slot_next        = frag_slot_reg;
        payload_address_next  = payload_address_reg;
        fragment_count_next   = fragment_count_reg;
        frame_length_next     = frame_length_reg;
        descriptor_count_next = descriptor_count_reg;
        last_frag_next        = last_frag_reg;
        stalled_next          = stalled_reg;

        case (act)
            tdlw_pkg::ACT_STALL:   stalled_next = 1'b1;
            tdlw_pkg::ACT_UNSTALL: stalled_next = 1'b0;
            tdlw_pkg::ACT_READ:
            begin
                case (phase_reg)
                    tdlw_pkg::PH_NEXT:
                    begin
                        next_descriptor_next = val;
                        phase_next           = tdlw_pkg::PH_HDR;
                    end
                    tdlw_pkg::PH_HDR:
                    begin
                        frame_header_next = val;
                        if (val[tdlw_pkg::HDR_DONE_BIT])
                        begin
                            list_pointer_next = walk_address_reg;
                            phase_next        = tdlw_pkg::PH_IDLE;
                        end
                        else
                        begin
                            frag_slot_next      = walk_address_reg + 32'd8;
                            fragment_count_next = 5'd0;
                            frame_length_next   = 13'd0;
                            last_frag_next      = 1'b0;
                            phase_next          = tdlw_pkg::PH_FADDR;
                        end
                    end
                    tdlw_pkg::PH_FADDR:
                    begin
                        payload_address_next = val;
                        phase_next           = tdlw_pkg::PH_FLEN;
                    end
                    tdlw_pkg::PH_FLEN:
                    begin
                        last_frag_next      = lfs_eff;
                        fragment_count_next = fc_eff;
                        frag_slot_next      = fsa_eff;
                        if (len_c != 13'd0)
                        begin
                            frame_length_next = frame_length_reg + len_c;
                            phase_next        = tdlw_pkg::PH_COPY;
                        end
                    end
                    default: ;
                endcase
            end
            tdlw_pkg::ACT_BUS_ERR:
            begin
                if (phase_reg == tdlw_pkg::PH_NEXT || phase_reg == tdlw_pkg::PH_HDR)
                begin
                    list_pointer_next = walk_address_reg;
                    phase_next        = tdlw_pkg::PH_IDLE;
                end
                else if (!is_idle)
                begin
                    phase_next = tdlw_pkg::PH_IDLE;
                end
            end
            default: ;
        endcase

        // fragment done: fetch the next pair or close the descriptor
        if (go_cont)
        begin
            phase_next = tdlw_pkg::PH_FADDR;
        end
        else if (go_finish)
        begin
            descriptor_count_next = dc_inc;
            if (go_chain)
            begin
                walk_address_next = next_descriptor_reg;
                phase_next        = tdlw_pkg::PH_NEXT;
            end
            else
            begin
                list_pointer_next = next_descriptor_reg;
                phase_next        = tdlw_pkg::PH_IDLE;
            end
        end

        if (go_kick)
        begin
            descriptor_count_next = 7'd0;
            walk_address_next     = lp_wr;
            phase_next            = tdlw_pkg::PH_NEXT;
        end
    end

    // results of this event
    always_comb
    begin
        logic [2:0] n;
        n = 3'd0;
        bundle_next = '0;

        if (act == tdlw_pkg::ACT_READ)
        begin
            case (phase_reg)
                tdlw_pkg::PH_NEXT:
                begin
                    bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_READ,
                        walk_address_reg + 32'd4, 32'd0, 13'd0, 1'b0, 1'b0, 1'b0);
                    n = n + 3'd1;
                end
                tdlw_pkg::PH_HDR:
                begin
                    if (!val[tdlw_pkg::HDR_DONE_BIT])
                    begin
                        bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_READ,
                            walk_address_reg + 32'd8, 32'd0, 13'd0, 1'b0, 1'b0, 1'b0);
                        n = n + 3'd1;
                    end
                end
                tdlw_pkg::PH_FADDR:
                begin
                    bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_READ,
                        frag_slot_reg + 32'd4, 32'd0, 13'd0, 1'b0, 1'b0, 1'b0);
                    n = n + 3'd1;
                end
                tdlw_pkg::PH_FLEN:
                begin
                    if (len_c != 13'd0)
                    begin
                        bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_COPY,
                            payload_address_reg, {19'd0, len_c}, frame_length_reg,
                            1'b0, 1'b0, 1'b0);
                        n = n + 3'd1;
                    end
                end
                default: ;
            endcase
        end

        // next fragment pair
        if (go_cont)
        begin
            bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_READ, fsa_eff,
                32'd0, 13'd0, 1'b0, 1'b0, 1'b0);
            n = n + 3'd1;
        end

        // send a non-empty frame, write back, then follow the chain if allowed
        if (go_finish)
        begin
            if (frame_length_reg != 13'd0)
            begin
                bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_SEND, 32'd0,
                    {19'd0, frame_length_reg}, 13'd0, 1'b0, 1'b0, 1'b0);
                n = n + 3'd1;
            end
            bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_WRITE,
                walk_address_reg + 32'd4, frame_header_reg | tdlw_pkg::HDR_DONE, 13'd0,
                frame_header_reg[tdlw_pkg::HDR_DN_IND_BIT],
                frame_header_reg[tdlw_pkg::HDR_TX_IND_BIT], 1'b0);
            n = n + 3'd1;
            if (go_chain)
            begin
                bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_READ,
                    next_descriptor_reg, 32'd0, 13'd0, 1'b0, 1'b0, 1'b0);
                n = n + 3'd1;
            end
        end

        if (go_kick)
        begin
            bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_READ, lp_wr,
                32'd0, 13'd0, 1'b0, 1'b0, 1'b0);
            n = n + 3'd1;
        end

        // bus error while a read or copy is outstanding
        if (act == tdlw_pkg::ACT_BUS_ERR && !is_idle)
        begin
            bundle_next.res[n[1:0]] = tdlw_pkg::mk_res(tdlw_pkg::REQ_NONE, 32'd0,
                32'd0, 13'd0, 1'b0, 1'b0, 1'b1);
            n = n + 3'd1;
        end

        // status-only result when nothing is requested
        if (n == 3'd0)
        begin
            bundle_next.res[0] = tdlw_pkg::mk_res(tdlw_pkg::REQ_NONE, 32'd0, 32'd0,
                13'd0, 1'b0, 1'b0, 1'b0);
            n = 3'd1;
        end

        bundle_next.cnt = n[1:0];
        for (int k = 0; k < 3; k++)
        begin
            bundle_next.res[k].list_pointer_now = list_pointer_next;
            bundle_next.res[k].engine_busy      = (phase_next != tdlw_pkg::PH_IDLE);
            bundle_next.res[k].last_result      = (3'(k) == n - 3'd1);
        end
    end

    // buffer occupancy
    always_comb
    begin
        count_next = count_reg;
        if (evt_fire && !pop_item)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!evt_fire && pop_item)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // walker state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= tdlw_pkg::PH_IDLE;
            list_pointer_reg     <= '0;
            walk_address_reg     <= '0;
            next_descriptor_reg  <= '0;
            frame_header_reg     <= '0;
            frag_slot_reg        <= '0;
            payload_address_reg  <= '0;
            fragment_count_reg   <= '0;
            frame_length_reg     <= '0;
            descriptor_count_reg <= '0;
            last_frag_reg        <= 1'b0;
            stalled_reg          <= 1'b0;
        end
        else if (evt_fire)
        begin
            phase_reg            <= phase_next;
            list_pointer_reg     <= list_pointer_next;
            walk_address_reg     <= walk_address_next;
            next_descriptor_reg  <= next_descriptor_next;
            frame_header_reg     <= frame_header_next;
            frag_slot_reg        <= frag_slot_next;
            payload_address_reg  <= payload_address_next;
            fragment_count_reg   <= fragment_count_next;
            frame_length_reg     <= frame_length_next;
            descriptor_count_reg <= descriptor_count_next;
            last_frag_reg        <= last_frag_next;
            stalled_reg          <= stalled_next;
        end
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (evt_fire)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_item)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                sub_reg    <= 2'd0;
            end
            else if (res_fire)
            begin
                sub_reg <= sub_reg + 2'd1;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            fifo_reg[wr_ptr_reg] <= bundle_next;
        end
    end

`include "tx_descriptor_list_walker_macros.svh"

    `TDLW_ASSERT_IMPLIES(a_bundle_index, res_valid,
        (fifo_reg[rd_ptr_reg].cnt != 2'd0) && (sub_reg < fifo_reg[rd_ptr_reg].cnt))
    `TDLW_ASSERT_IMPLIES(a_copy_length, phase_reg == tdlw_pkg::PH_COPY,
        (frame_length_reg != 13'd0) &&
        (frame_length_reg <= 13'(tdlw_pkg::MAX_FRAME_BYTES)))
    `TDLW_ASSERT_IMPLIES(a_frag_limit, phase_reg == tdlw_pkg::PH_FLEN,
        fragment_count_reg < 5'(tdlw_pkg::MAX_FRAGMENTS))
    `TDLW_ASSERT_NEXT(a_stall_taken,
        evt_fire && evt_data.action == tdlw_pkg::ACT_STALL, stalled_reg)

endmodule

`default_nettype wire

>>> bench/tx_descriptor_list_walker_tb.sv
`timescale 1ns / 100ps

module tx_descriptor_list_walker_tb;

    logic              clk;
    logic              rst_n;
    logic              evt_valid;
    logic              evt_ready;
    tdlw_pkg::event_t  evt_data;
    logic              res_valid;
    logic              res_ready;
    tdlw_pkg::result_t res_data;

    tx_descriptor_list_walker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // walker state as the bench predicts it
    tdlw_pkg::phase_t wk_phase;
    logic [31:0]      wk_list_ptr;
    logic [31:0]      wk_desc_addr;
    logic [31:0]      wk_next_desc;
    logic [31:0]      wk_header;
    logic [31:0]      wk_slot_addr;
    logic [31:0]      wk_payload_addr;
    logic [4:0]       wk_frag_cnt;
    logic [12:0]      wk_frame_len;
    logic [6:0]       wk_desc_cnt;
    logic             wk_last_frag;
    logic             wk_stalled;

    tdlw_pkg::result_t step_requests[$];
    tdlw_pkg::result_t expected_requests[$];

    int n_errors;
    int items_sent;
    int evt_gap_max;
    int res_stall_max;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Walker prediction
    // ---------------------------------------------------------------
    function automatic void reset_walk_model();
        wk_phase        = tdlw_pkg::PH_IDLE;
        wk_list_ptr     = '0;
        wk_desc_addr    = '0;
        wk_next_desc    = '0;
        wk_header       = '0;
        wk_slot_addr    = '0;
        wk_payload_addr = '0;
        wk_frag_cnt     = '0;
        wk_frame_len    = '0;
        wk_desc_cnt     = '0;
        wk_last_frag    = 1'b0;
        wk_stalled      = 1'b0;
    endfunction

    function automatic void push_request(logic [2:0] kind, logic [31:0] addr,
                                         logic [31:0] data, logic [12:0] off,
                                         logic dn, logic tx, logic fail);
        tdlw_pkg::result_t r;
        r = '0;
        r.request_kind       = kind;
        r.bus_address        = addr;
        r.request_data       = data;
        r.frame_offset       = off;
        r.download_done_flag = dn;
        r.transmit_done_flag = tx;
        r.adapter_fail_flag  = fail;
        if (step_requests.size() < 3)
            step_requests.push_back(r);
    endfunction

    function automatic void begin_descriptor(logic [31:0] addr);
        wk_desc_addr = addr;
        wk_phase     = tdlw_pkg::PH_NEXT;
        push_request(tdlw_pkg::REQ_READ, addr, '0, '0, 1'b0, 1'b0, 1'b0);
    endfunction

    function automatic void try_kick();
        if (wk_phase == tdlw_pkg::PH_IDLE && !wk_stalled && wk_list_ptr != 0)
        begin
            wk_desc_cnt = '0;
            begin_descriptor(wk_list_ptr);
        end
    endfunction

    // send a non-empty frame, write the header back, then follow the link or stop
    function automatic void close_descriptor();
        if (wk_frame_len != 0)
            push_request(tdlw_pkg::REQ_SEND, '0, {19'd0, wk_frame_len}, '0,
                         1'b0, 1'b0, 1'b0);
        push_request(tdlw_pkg::REQ_WRITE, wk_desc_addr + 32'd4,
                     wk_header | tdlw_pkg::HDR_DONE, '0,
                     wk_header[tdlw_pkg::HDR_DN_IND_BIT],
                     wk_header[tdlw_pkg::HDR_TX_IND_BIT], 1'b0);
        wk_desc_cnt = wk_desc_cnt + 7'd1;
        if (wk_next_desc != 0 && !wk_stalled && wk_desc_cnt < tdlw_pkg::MAX_DESCRIPTORS)
        begin
            begin_descriptor(wk_next_desc);
        end
        else
        begin
            wk_list_ptr = wk_next_desc;
            wk_phase    = tdlw_pkg::PH_IDLE;
        end
    endfunction

    function automatic void next_fragment_or_close();
        if (!wk_last_frag && wk_frag_cnt < tdlw_pkg::MAX_FRAGMENTS)
        begin
            wk_phase = tdlw_pkg::PH_FADDR;
            push_request(tdlw_pkg::REQ_READ, wk_slot_addr, '0, '0, 1'b0, 1'b0, 1'b0);
        end
        else
        begin
            close_descriptor();
        end
    endfunction

    function automatic void take_read_data(logic [31:0] v);
        int          room;
        logic [12:0] len;
        case (wk_phase)
            tdlw_pkg::PH_NEXT:
            begin
                wk_next_desc = v;
                wk_phase     = tdlw_pkg::PH_HDR;
                push_request(tdlw_pkg::REQ_READ, wk_desc_addr + 32'd4, '0, '0,
                             1'b0, 1'b0, 1'b0);
            end
            tdlw_pkg::PH_HDR:
            begin
                wk_header = v;
                if (v[tdlw_pkg::HDR_DONE_BIT])
                begin
                    // stale descriptor stops the walk on itself
                    wk_list_ptr = wk_desc_addr;
                    wk_phase    = tdlw_pkg::PH_IDLE;
                end
                else
                begin
                    wk_slot_addr = wk_desc_addr + 32'd8;
                    wk_frag_cnt  = '0;
                    wk_frame_len = '0;
                    wk_last_frag = 1'b0;
                    wk_phase     = tdlw_pkg::PH_FADDR;
                    push_request(tdlw_pkg::REQ_READ, wk_slot_addr, '0, '0,
                                 1'b0, 1'b0, 1'b0);
                end
            end
            tdlw_pkg::PH_FADDR:
            begin
                wk_payload_addr = v;
                wk_phase        = tdlw_pkg::PH_FLEN;
                push_request(tdlw_pkg::REQ_READ, wk_slot_addr + 32'd4, '0, '0,
                             1'b0, 1'b0, 1'b0);
            end
            tdlw_pkg::PH_FLEN:
            begin
                wk_last_frag = v[tdlw_pkg::FRAG_END_BIT];
                len  = v[12:0];
                room = (wk_frame_len < tdlw_pkg::MAX_FRAME_BYTES) ?
                       tdlw_pkg::MAX_FRAME_BYTES - wk_frame_len : 0;
                if (len > room)
                    len = 13'(room);
                wk_frag_cnt  = wk_frag_cnt + 5'd1;
                wk_slot_addr = wk_slot_addr + 32'd8;
                if (len != 0)
                begin
                    push_request(tdlw_pkg::REQ_COPY, wk_payload_addr, {19'd0, len},
                                 wk_frame_len, 1'b0, 1'b0, 1'b0);
                    wk_frame_len = wk_frame_len + len;
                    wk_phase     = tdlw_pkg::PH_COPY;
                end
                else
                begin
                    next_fragment_or_close();
                end
            end
            default: ;
        endcase
    endfunction

    // one accepted transaction -> queued expected requests
    function automatic void walk_engine_step(logic [2:0] act, logic [31:0] v);
        step_requests.delete();
        case (act)
            tdlw_pkg::ACT_WR_FULL:
            begin
                if (wk_phase == tdlw_pkg::PH_IDLE)
                begin
                    wk_list_ptr = v;
                    try_kick();
                end
            end
            tdlw_pkg::ACT_WR_LOW:
            begin
                if (wk_phase == tdlw_pkg::PH_IDLE)
                    wk_list_ptr[15:0] = v[15:0];
            end
            tdlw_pkg::ACT_WR_HIGH:
            begin
                if (wk_phase == tdlw_pkg::PH_IDLE)
                begin
                    wk_list_ptr[31:16] = v[15:0];
                    try_kick();
                end
            end
            tdlw_pkg::ACT_STALL: wk_stalled = 1'b1;
            tdlw_pkg::ACT_UNSTALL:
            begin
                wk_stalled = 1'b0;
                try_kick();
            end
            tdlw_pkg::ACT_READ: take_read_data(v);
            tdlw_pkg::ACT_COPIED:
            begin
                if (wk_phase == tdlw_pkg::PH_COPY)
                    next_fragment_or_close();
            end
            default:
            begin
                // bus error: pointer falls back to the descriptor only on link/header reads
                if (wk_phase == tdlw_pkg::PH_NEXT || wk_phase == tdlw_pkg::PH_HDR)
                begin
                    wk_list_ptr = wk_desc_addr;
                    wk_phase    = tdlw_pkg::PH_IDLE;
                    push_request(tdlw_pkg::REQ_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
                end
                else if (wk_phase != tdlw_pkg::PH_IDLE)
                begin
                    wk_phase = tdlw_pkg::PH_IDLE;
                    push_request(tdlw_pkg::REQ_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
                end
            end
        endcase
        if (step_requests.size() == 0)
            push_request(tdlw_pkg::REQ_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        foreach (step_requests[i])
        begin
            step_requests[i].list_pointer_now = wk_list_ptr;
            step_requests[i].engine_busy      = (wk_phase != tdlw_pkg::PH_IDLE);
            step_requests[i].last_result      = (i == step_requests.size() - 1);
            expected_requests.push_back(step_requests[i]);
        end
    endfunction

    // ---------------------------------------------------------------
    // Event side
    // ---------------------------------------------------------------
    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic send_event(logic [2:0] act, logic [31:0] v);
        int               gap;
        tdlw_pkg::event_t ev;
        gap = (evt_gap_max > 0) ? $urandom_range(0, evt_gap_max) : 0;
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev.action = act;
        ev.value  = v;
        evt_valid <= 1'b1;
        evt_data  <= ev;
        do @(posedge clk); while (!evt_ready);
        walk_engine_step(act, v);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        evt_valid <= 1'b0;
        while (expected_requests.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // answer whatever the walker is waiting for, with optional noise
    task automatic answer_step(int end_pct, int zero_next_pct, int zero_len_pct,
                               int stale_pct, int noise_pct);
        logic [31:0] v;
        v = $urandom;
        if (chance(noise_pct))
        begin
            send_event(3'($urandom_range(0, 7)), v);
        end
        else
        begin
            case (wk_phase)
                tdlw_pkg::PH_NEXT:
                begin
                    if (chance(zero_next_pct))
                        v = '0;
                    else if (v == 0)
                        v = 32'h4;
                    send_event(tdlw_pkg::ACT_READ, v);
                end
                tdlw_pkg::PH_HDR:
                begin
                    v[tdlw_pkg::HDR_DONE_BIT] = chance(stale_pct);
                    send_event(tdlw_pkg::ACT_READ, v);
                end
                tdlw_pkg::PH_FADDR: send_event(tdlw_pkg::ACT_READ, v);
                tdlw_pkg::PH_FLEN:
                begin
                    v[tdlw_pkg::FRAG_END_BIT] = chance(end_pct);
                    if (chance(zero_len_pct))
                        v[12:0] = '0;
                    else if (chance(50))
                        v[12:0] = 13'($urandom_range(1, 64));
                    send_event(tdlw_pkg::ACT_READ, v);
                end
                tdlw_pkg::PH_COPY: send_event(tdlw_pkg::ACT_COPIED, v);
                default: send_event(tdlw_pkg::ACT_UNSTALL, v);
            endcase
        end
    endtask

    // bring the walker to idle and unstalled
    task automatic settle_idle();
        while (wk_phase != tdlw_pkg::PH_IDLE || wk_stalled)
        begin
            if (wk_phase != tdlw_pkg::PH_IDLE)
                answer_step(100, 100, 0, 0, 0);
            else
                send_event(tdlw_pkg::ACT_UNSTALL, $urandom);
        end
    endtask

    task automatic start_random_walk();
        int r;
        r = $urandom_range(0, 9);
        if (wk_stalled && chance(60))
        begin
            send_event(tdlw_pkg::ACT_UNSTALL, $urandom);
        end
        else if (r < 6)
        begin
            send_event(tdlw_pkg::ACT_WR_FULL, $urandom);
        end
        else if (r < 8)
        begin
            send_event(tdlw_pkg::ACT_WR_LOW, $urandom);
            send_event(tdlw_pkg::ACT_WR_HIGH, $urandom);
        end
        else
        begin
            send_event(3'($urandom_range(0, 7)), $urandom);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_cases();
        evt_gap_max   = 11;
        res_stall_max = 11;
        // split pointer write, kick on high half, pointer write while busy
        send_event(tdlw_pkg::ACT_WR_LOW,  32'hABCD_1234);
        send_event(tdlw_pkg::ACT_WR_HIGH, 32'h1234_8000);
        send_event(tdlw_pkg::ACT_WR_FULL, 32'h0000_5555);
        // max-length fragment clamped to the frame limit, both indications
        send_event(tdlw_pkg::ACT_READ,    32'hFFFF_FFF0);
        send_event(tdlw_pkg::ACT_READ,    32'h8000_8000);
        send_event(tdlw_pkg::ACT_READ,    32'hFFFF_FFFF);
        send_event(tdlw_pkg::ACT_READ,    32'hFFFF_FFFF);
        send_event(tdlw_pkg::ACT_COPIED,  32'h0000_0000);
        // next descriptor already done
        send_event(tdlw_pkg::ACT_READ,    32'h0000_0000);
        send_event(tdlw_pkg::ACT_READ,    32'h0001_0000);
        // stray events while idle, zero pointer
        send_event(tdlw_pkg::ACT_COPIED,  32'hFFFF_FFFF);
        send_event(tdlw_pkg::ACT_BUS_ERR, 32'h0000_0000);
        send_event(tdlw_pkg::ACT_WR_FULL, 32'h0000_0000);
        // stalled write does not kick; unstall does
        send_event(tdlw_pkg::ACT_STALL,   32'h0000_0000);
        send_event(tdlw_pkg::ACT_WR_FULL, 32'h0000_0200);
        send_event(tdlw_pkg::ACT_UNSTALL, 32'h0000_0000);
        // zero-length frame: header written back, no send
        send_event(tdlw_pkg::ACT_READ,    32'h0000_0300);
        send_event(tdlw_pkg::ACT_READ,    32'h0000_7FFF);
        send_event(tdlw_pkg::ACT_READ,    32'h0000_0000);
        send_event(tdlw_pkg::ACT_READ,    32'h8000_0000);
        // stall mid descriptor takes effect at its end
        send_event(tdlw_pkg::ACT_STALL,   32'h0000_0000);
        send_event(tdlw_pkg::ACT_READ,    32'h0000_0400);
        send_event(tdlw_pkg::ACT_READ,    32'h0000_8000);
        send_event(tdlw_pkg::ACT_READ,    32'h0000_1234);
        send_event(tdlw_pkg::ACT_READ,    32'h8000_0010);
        send_event(tdlw_pkg::ACT_COPIED,  32'h0000_0000);
        // link read fails
        send_event(tdlw_pkg::ACT_UNSTALL, 32'h0000_0000);
        send_event(tdlw_pkg::ACT_BUS_ERR, 32'hFFFF_FFFF);
    endtask

    task automatic test_fragment_limit();
        evt_gap_max   = 0;
        res_stall_max = 0;
        settle_idle();
        send_event(tdlw_pkg::ACT_WR_FULL, $urandom | 32'h1);
        while (wk_phase != tdlw_pkg::PH_IDLE)
            answer_step(0, 100, 10, 0, 0);
    endtask

    task automatic test_descriptor_limit();
        evt_gap_max   = 11;
        res_stall_max = 0;
        settle_idle();
        send_event(tdlw_pkg::ACT_WR_FULL, $urandom | 32'h1);
        while (wk_phase != tdlw_pkg::PH_IDLE)
            answer_step(100, 0, 85, 0, 0);
    endtask

    task automatic test_random_walks();
        evt_gap_max   = 11;
        res_stall_max = 11;
        while (items_sent < 400)
        begin
            if (wk_phase == tdlw_pkg::PH_IDLE)
                start_random_walk();
            else
                answer_step(25, 30, 15, 5, 10);
        end
        // hold off until every request is out
        wait_for_drain();
        evt_gap_max   = 0;
        res_stall_max = 11;
        while (items_sent < 470)
        begin
            if (wk_phase == tdlw_pkg::PH_IDLE)
                start_random_walk();
            else
                answer_step(25, 30, 15, 5, 10);
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, then compare each transaction
    // ---------------------------------------------------------------
    initial
    begin
        int stall;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = (res_stall_max > 0) ? $urandom_range(0, res_stall_max) : 0;
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        tdlw_pkg::result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_requests.size() == 0)
            begin
                $error("request_kind: no transaction expected, got %h",
                       res_data.request_kind);
                n_errors++;
            end
            else
            begin
                want = expected_requests.pop_front();
                check_field("request_kind", want.request_kind, res_data.request_kind);
                check_field("bus_address", want.bus_address, res_data.bus_address);
                check_field("request_data", want.request_data, res_data.request_data);
                check_field("frame_offset", want.frame_offset, res_data.frame_offset);
                check_field("download_done_flag", want.download_done_flag,
                            res_data.download_done_flag);
                check_field("transmit_done_flag", want.transmit_done_flag,
                            res_data.transmit_done_flag);
                check_field("adapter_fail_flag", want.adapter_fail_flag,
                            res_data.adapter_fail_flag);
                check_field("list_pointer_now", want.list_pointer_now,
                            res_data.list_pointer_now);
                check_field("engine_busy", want.engine_busy, res_data.engine_busy);
                check_field("last_result", want.last_result, res_data.last_result);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        evt_valid     = 1'b0;
        evt_data      = '0;
        n_errors      = 0;
        items_sent    = 0;
        evt_gap_max   = 11;
        res_stall_max = 11;
        reset_walk_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        wait_for_drain();
        test_fragment_limit();
        wait_for_drain();
        test_descriptor_limit();
        test_random_walks();

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
